[sv/bpwp_pkg.sv]
// Shared types, constants and helper functions for the bit-plane word packer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bpwp_pkg;

  localparam int WORD_BITS   = 32;
  localparam int MAX_PLANES  = 8;
  localparam int MAX_DEPTH   = 4096;

  localparam int SAMPLE_W    = 8;
  localparam int BIT_POS_W   = $clog2(WORD_BITS);
  localparam int PLANE_IDX_W = 3;
  localparam int PLANE_CNT_W = 4;
  localparam int DEPTH_POS_W = $clog2(MAX_DEPTH);
  localparam int DEPTH_CFG_W = 13;
  localparam int ADDR_W      = 24;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_DEPTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BITS_PER_VALUE = 1'b1;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t [MAX_PLANES-1:0]   words;
    logic [PLANE_IDX_W-1:0]   last_plane;
    logic [ADDR_W-1:0]        base;
  } group_t;

  // Clamp the programmed depth into 1..MAX_DEPTH.
  function automatic logic [DEPTH_CFG_W-1:0] eff_depth(input logic [DEPTH_CFG_W-1:0] d);
    logic [DEPTH_CFG_W-1:0] r;
    r = d;
    if (d == '0) r = DEPTH_CFG_W'(1);
    else if (d > DEPTH_CFG_W'(MAX_DEPTH)) r = DEPTH_CFG_W'(MAX_DEPTH);
    return r;
  endfunction

  // Clamp the programmed plane count into 1..MAX_PLANES.
  function automatic logic [PLANE_CNT_W-1:0] eff_planes(input logic [PLANE_CNT_W-1:0] p);
    logic [PLANE_CNT_W-1:0] r;
    r = p;
    if (p == '0) r = PLANE_CNT_W'(1);
    else if (p > PLANE_CNT_W'(MAX_PLANES)) r = PLANE_CNT_W'(MAX_PLANES);
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/bpwp_group_buffer.sv]
// Holding register for one finished plane group, drained one word per request.
// Depends on bpwp_pkg.
`default_nettype none

module bpwp_group_buffer (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire bpwp_pkg::group_t              load_group,
  output logic                               can_load,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bpwp_pkg::WORD_BITS-1:0]     packed_word,
  output logic [bpwp_pkg::PLANE_IDX_W-1:0]   plane_index,
  output logic [bpwp_pkg::ADDR_W-1:0]        word_address,
  output logic                               group_last
);
  import bpwp_pkg::*;

  logic                   busy;
  logic [PLANE_IDX_W-1:0] idx;
  logic [PLANE_IDX_W-1:0] last_plane;
  logic [ADDR_W-1:0]      addr;
  word_t [MAX_PLANES-1:0] words;

  logic take;
  logic last_take;

  assign take      = busy && !out_stall;
  assign last_take = take && (idx == last_plane);
  assign can_load  = !busy || last_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (last_take) begin
      busy <= 1'b0;
    end else if (take) begin
      idx <= idx + PLANE_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words      <= load_group.words;
      last_plane <= load_group.last_plane;
      addr       <= load_group.base;
    end else if (take) begin
      addr <= addr + ADDR_W'(1);
    end
  end

  assign out_valid    = busy;
  assign packed_word  = words[idx];
  assign plane_index  = idx;
  assign word_address = addr;
  assign group_last   = (idx == last_plane);

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!busy || last_take))
    else $error("group loaded over an undrained group");

  a_idx_in_group: assert property (@(posedge clk) disable iff (rst)
    busy |-> (idx <= last_plane))
    else $error("drain index ran past the last plane");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (last_take && !load) |=> !busy)
    else $error("buffer still busy after last word taken");

  a_addr_steps: assert property (@(posedge clk) disable iff (rst)
    (take && !last_take && !load) |=> (addr == $past(addr) + ADDR_W'(1)))
    else $error("word address did not advance by one");
`endif

endmodule

`default_nettype wire

[sv/bit_plane_word_packer_top.sv]
// Top level of the bit-plane word packer: config registers, plane accumulators
// and group control. Depends on bpwp_pkg and bpwp_group_buffer.
`default_nettype none

// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+--------------------------------------
// input     | in        | in_valid / in_stall   | sample_value[7:0]
// output    | out       | out_valid / out_stall | packed_word, plane_index, word_address,
//           |           |                       | group_last
// config    | in        | cfg_wr_en             | cfg_addr, cfg_wdata (no read-back)
//
// A sample request is folded into the plane accumulators at the edge that takes it;
// one sample per cycle is sustained while groups are long and the output is not held back.
// A closed group loads the holding buffer and drains one word per cycle while out_stall
// is low, from the next cycle on, one word per plane; that drain sets the rate for short groups.
// in_stall is high only while the next sample would close a group and the buffer holds
// a group whose last word is not leaving at this edge. rst restores depth 32, two planes.

module bit_plane_word_packer_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [bpwp_pkg::CFG_INDEX_W-1:0] cfg_addr,
  input  wire logic [bpwp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // samples
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bpwp_pkg::SAMPLE_W-1:0] sample_value,
  // plane words
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bpwp_pkg::WORD_BITS-1:0]     packed_word,
  output logic [bpwp_pkg::PLANE_IDX_W-1:0]   plane_index,
  output logic [bpwp_pkg::ADDR_W-1:0]        word_address,
  output logic                               group_last
);
  import bpwp_pkg::*;

  // Configuration registers.
  logic [DEPTH_CFG_W-1:0] channel_depth;
  logic [PLANE_CNT_W-1:0] bits_per_value;

  // Packing state.
  word_t [MAX_PLANES-1:0] plane_accumulators;
  word_t [MAX_PLANES-1:0] acc_next;
  logic [BIT_POS_W-1:0]   bit_position;
  logic [DEPTH_POS_W-1:0] depth_position;
  logic [ADDR_W-1:0]      word_counter;

  logic [PLANE_CNT_W-1:0] planes;
  logic [DEPTH_CFG_W-1:0] depth;
  logic                   word_full;
  logic                   pixel_end;
  logic                   group_end;
  logic                   accept;
  logic                   can_load;
  group_t                 group;

  // Write config; only two registers exist, so every index lands on one.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_depth  <= DEPTH_CFG_W'(32);
      bits_per_value <= PLANE_CNT_W'(2);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_CHANNEL_DEPTH:  channel_depth  <= cfg_wdata[DEPTH_CFG_W-1:0];
        REG_BITS_PER_VALUE: bits_per_value <= cfg_wdata[PLANE_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign planes = eff_planes(bits_per_value);
  assign depth  = eff_depth(channel_depth);

  // Whether the next sample closes a group depends on state alone, so stall
  // never looks at the sample itself.
  assign word_full = (bit_position == BIT_POS_W'(WORD_BITS - 1));
  assign pixel_end = ((DEPTH_CFG_W'(depth_position) + DEPTH_CFG_W'(1)) >= depth);
  assign group_end = word_full || pixel_end;

  // Hold samples only when a closing sample would find the buffer occupied.
  assign in_stall = group_end && !can_load;
  assign accept   = in_valid && !in_stall;

  // Drop bit b of the sample into plane b at the current bit position.
  always_comb begin
    acc_next = plane_accumulators;
    for (int b = 0; b < MAX_PLANES; b++) begin
      if ((PLANE_CNT_W'(b) < planes) && sample_value[b]) begin
        acc_next[b][bit_position] = 1'b1;
      end
    end
  end

  assign group.words      = acc_next;
  assign group.last_plane = PLANE_IDX_W'(planes - PLANE_CNT_W'(1));
  assign group.base       = word_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_accumulators <= '0;
      bit_position       <= '0;
      depth_position     <= '0;
      word_counter       <= '0;
    end else if (accept) begin
      if (group_end) begin
        // Clear every plane, emitted or not, and advance the address by the group.
        plane_accumulators <= '0;
        bit_position       <= '0;
        word_counter       <= word_counter + ADDR_W'(planes);
        if (pixel_end) depth_position <= '0;
        else depth_position <= depth_position + DEPTH_POS_W'(1);
      end else begin
        plane_accumulators <= acc_next;
        bit_position       <= bit_position + BIT_POS_W'(1);
        depth_position     <= depth_position + DEPTH_POS_W'(1);
      end
    end
  end

  bpwp_group_buffer u_group_buffer (
    .clk          (clk),
    .rst          (rst),
    .load         (accept && group_end),
    .load_group   (group),
    .can_load     (can_load),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packed_word  (packed_word),
    .plane_index  (plane_index),
    .word_address (word_address),
    .group_last   (group_last)
  );

`ifndef SYNTHESIS
  a_group_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && group_end) |=> (bit_position == '0 && plane_accumulators == '0))
    else $error("accumulators not cleared after group");

  a_group_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && group_end) |=> out_valid)
    else $error("closed group did not reach the output");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    DEPTH_CFG_W'(depth_position) < DEPTH_CFG_W'(MAX_DEPTH))
    else $error("depth position beyond maximum depth");
`endif

endmodule

`default_nettype wire

[bench/bit_plane_word_packer_top_test.sv]
// Self-checking bench for bit_plane_word_packer_top: predicts every plane word from
// the accepted sample requests and the register settings, and checks the words in order.
// Depends on bpwp_pkg and the packer RTL only.
module bit_plane_word_packer_top_test;
  import bpwp_pkg::*;

  // One expected or observed plane word.
  typedef struct packed {
    logic [WORD_BITS-1:0]   word;
    logic [PLANE_IDX_W-1:0] plane;
    logic [ADDR_W-1:0]      addr;
    logic                   last;
  } plane_word_t;

  // Predicts the plane words the packer owes and holds them until they arrive.
  class plane_group_predictor;
    logic [DEPTH_CFG_W-1:0] depth_reg;
    logic [PLANE_CNT_W-1:0] planes_reg;
    logic [WORD_BITS-1:0]   plane_acc [MAX_PLANES];
    int unsigned            fill;
    int unsigned            depth_count;
    logic [ADDR_W-1:0]      next_addr;
    plane_word_t            due_words [$];
    int unsigned            mismatches;
    int unsigned            samples_taken;
    int unsigned            words_matched;
    int unsigned            groups_made;

    function new();
      depth_reg     = DEPTH_CFG_W'(32);
      planes_reg    = PLANE_CNT_W'(2);
      foreach (plane_acc[i]) plane_acc[i] = '0;
      fill          = 0;
      depth_count   = 0;
      next_addr     = '0;
      mismatches    = 0;
      samples_taken = 0;
      words_matched = 0;
      groups_made   = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CHANNEL_DEPTH) depth_reg = data[DEPTH_CFG_W-1:0];
      else if (idx == REG_BITS_PER_VALUE) planes_reg = data[PLANE_CNT_W-1:0];
    endfunction

    // Fold one sample into the planes; close the group on a full word or pixel end.
    function void take_sample(logic [SAMPLE_W-1:0] v);
      int unsigned planes;
      int unsigned depth_lim;
      bit          word_full;
      bit          pixel_end;
      plane_word_t w;
      planes = 32'(planes_reg);
      if (planes == 0) planes = 1;
      if (planes > MAX_PLANES) planes = MAX_PLANES;
      depth_lim = 32'(depth_reg);
      if (depth_lim == 0) depth_lim = 1;
      if (depth_lim > MAX_DEPTH) depth_lim = MAX_DEPTH;
      for (int b = 0; b < planes; b++) plane_acc[b][fill] = v[b];
      fill++;
      depth_count++;
      samples_taken++;
      word_full = (fill >= WORD_BITS);
      pixel_end = (depth_count >= depth_lim);
      if (word_full || pixel_end) begin
        for (int b = 0; b < planes; b++) begin
          w.word  = plane_acc[b];
          w.plane = PLANE_IDX_W'(b);
          w.addr  = next_addr;
          w.last  = (b + 1 == planes);
          due_words.push_back(w);
          next_addr = next_addr + ADDR_W'(1);
        end
        foreach (plane_acc[i]) plane_acc[i] = '0;
        fill = 0;
        if (pixel_end) depth_count = 0;
        groups_made++;
      end
    endfunction

    function void match_word(plane_word_t got);
      plane_word_t exp;
      bit          bad;
      if (due_words.size() == 0) begin
        $display("%0t: unexpected plane word %h plane %0d addr %0d last %0d",
                 $time, got.word, got.plane, got.addr, got.last);
        mismatches++;
        return;
      end
      exp = due_words.pop_front();
      bad = 1'b0;
      if (got.word !== exp.word) begin
        $display("%0t: packed_word expected %h got %h", $time, exp.word, got.word);
        bad = 1'b1;
      end
      if (got.plane !== exp.plane) begin
        $display("%0t: plane_index expected %0d got %0d", $time, exp.plane, got.plane);
        bad = 1'b1;
      end
      if (got.addr !== exp.addr) begin
        $display("%0t: word_address expected %0d got %0d", $time, exp.addr, got.addr);
        bad = 1'b1;
      end
      if (got.last !== exp.last) begin
        $display("%0t: group_last expected %0d got %0d", $time, exp.last, got.last);
        bad = 1'b1;
      end
      if (bad) mismatches++;
      words_matched++;
    endfunction
  endclass

  localparam int HOLD_CYCLES = 200;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_valid;
  logic                   in_stall;
  logic [SAMPLE_W-1:0]    sample_value;
  logic                   out_valid;
  logic                   out_stall;
  logic [WORD_BITS-1:0]   packed_word;
  logic [PLANE_IDX_W-1:0] plane_index;
  logic [ADDR_W-1:0]      word_address;
  logic                   group_last;

  logic                   hold_req;
  bit                     hold_done;
  int unsigned            reg_writes;
  int unsigned            held_sample_cycles;

  plane_group_predictor   packer;

  bit_plane_word_packer_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_value (sample_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packed_word  (packed_word),
    .plane_index  (plane_index),
    .word_address (word_address),
    .group_last   (group_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a correct run ends long before this.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned rand_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sample the output handshake at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        packer.match_word('{word: packed_word, plane: plane_index,
                            addr: word_address, last: group_last});
      if (in_valid && in_stall) held_sample_cycles++;
    end
  end

  // Receiver: stretches of random back-pressure, some with none at all. Once asked,
  // hold off for a long count so the holding buffer fills and the input stalls.
  initial begin
    int unsigned stretch;
    int unsigned mode;
    int unsigned g;
    out_stall <= 1'b0;
    hold_done  = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stretch = $urandom_range(5, 60);
        mode    = $urandom_range(0, 3);
        repeat (stretch) begin
          if (hold_req && !hold_done) break;
          g = (mode == 0) ? 0 : rand_gap();
          if (g > 0) begin
            out_stall <= 1'b1;
            repeat (g) @(posedge clk);
          end
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // Write one register while the block is idle; drop the enable after the edge that writes it.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    packer.write_reg(idx, data);
    reg_writes++;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one sample request, after an optional gap; hold it until taken.
  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit gaps_on);
    int unsigned g;
    g = gaps_on ? rand_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= v;
    do @(posedge clk); while (in_stall);
    packer.take_sample(v);
  endtask

  // Stop offering and let every owed word drain, then idle briefly before returning.
  task automatic drain_words();
    in_valid <= 1'b0;
    while (packer.due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned            n;
    int unsigned            random_items;
    int unsigned            phase_no;
    int unsigned            pick;
    logic [CFG_DATA_W-1:0]  d;
    bit                     gaps_on;
    bit                     long_depth;

    packer             = new();
    reg_writes         = 0;
    held_sample_cycles = 0;
    rst          <= 1'b1;
    cfg_wr_en    <= 1'b0;
    cfg_addr     <= REG_CHANNEL_DEPTH;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    sample_value <= '0;
    hold_req     <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings (depth 32, two planes): leave a partial group open.
    send_sample(8'h00, 1'b0);
    send_sample(8'hFF, 1'b0);
    send_sample(8'hA5, 1'b0);
    drain_words();

    // Zero depth and zero planes, both taken as one; the open pixel is already
    // past the new depth, so the next sample closes it.
    write_reg(REG_CHANNEL_DEPTH, 13'd0);
    write_reg(REG_BITS_PER_VALUE, 13'd0);
    send_sample(8'hFF, 1'b1);
    send_sample(8'h00, 1'b1);
    drain_words();

    // Oversized depth and too many planes: clamp to the maximum of each.
    write_reg(REG_CHANNEL_DEPTH, 13'h1FFF);
    write_reg(REG_BITS_PER_VALUE, 13'd15);
    send_sample(8'hFF, 1'b0);
    send_sample(8'h80, 1'b0);
    send_sample(8'h01, 1'b0);
    send_sample(8'h7F, 1'b0);
    drain_words();

    // Shrink the depth mid-pixel with eight planes still active.
    write_reg(REG_CHANNEL_DEPTH, 13'd3);
    send_sample(8'h55, 1'b1);
    send_sample(8'hAA, 1'b1);
    send_sample(8'hC3, 1'b1);
    send_sample(8'h3C, 1'b1);
    drain_words();

    // One value per pixel, all eight planes: a full group per sample.
    write_reg(REG_CHANNEL_DEPTH, 13'd1);
    write_reg(REG_BITS_PER_VALUE, 13'd8);
    send_sample(8'h00, 1'b0);
    send_sample(8'hFF, 1'b0);
    drain_words();

    // Random phases, each under its own settings; registers change only once drained.
    random_items = 0;
    phase_no     = 0;
    while (random_items < 340) begin
      gaps_on    = ($urandom_range(0, 3) != 0);
      long_depth = 1'b0;
      case (phase_no)
        0: begin
          write_reg(REG_CHANNEL_DEPTH, 13'd4096);
          write_reg(REG_BITS_PER_VALUE, {9'($urandom_range(0, 511)), 4'd8});
          long_depth = 1'b1;
        end
        1: begin
          write_reg(REG_CHANNEL_DEPTH, 13'd1);
          write_reg(REG_BITS_PER_VALUE, 13'd1);
        end
        2: begin
          // Short pixels, wide groups, and the receiver holding off meanwhile.
          write_reg(REG_CHANNEL_DEPTH, 13'd4);
          write_reg(REG_BITS_PER_VALUE, 13'd8);
          hold_req <= 1'b1;
          gaps_on   = 1'b0;
        end
        3: begin
          write_reg(REG_CHANNEL_DEPTH, 13'd64);
          write_reg(REG_BITS_PER_VALUE, 13'd4);
          long_depth = 1'b1;
        end
        default: begin
          if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5)      d = CFG_DATA_W'($urandom_range(1, 40));
            else if (pick == 6) d = 13'd1;
            else if (pick == 7) d = 13'd4096;
            else if (pick == 8) d = ($urandom_range(0, 1) != 0) ? 13'd0
                                    : CFG_DATA_W'($urandom_range(4097, 8191));
            else                d = CFG_DATA_W'($urandom_range(41, 200));
            write_reg(REG_CHANNEL_DEPTH, d);
            long_depth = (d > 40);
          end
          if ($urandom_range(0, 3) != 0)
            write_reg(REG_BITS_PER_VALUE, CFG_DATA_W'($urandom_range(0, 8191)));
        end
      endcase
      if (phase_no == 2)  n = 48;
      else if (long_depth) n = $urandom_range(40, 70);
      else                 n = $urandom_range(15, 45);
      repeat (n) send_sample(SAMPLE_W'($urandom_range(0, 255)), gaps_on);
      drain_words();
      random_items += n;
      phase_no++;
    end

    // All requests taken; drain_words has already waited out the tail.
    repeat (16) @(posedge clk);
    if (packer.due_words.size() != 0) begin
      $display("%0t: %0d plane words never arrived", $time, packer.due_words.size());
      packer.mismatches++;
    end
    $display("Run covered %0d samples under %0d register writes; %0d plane words in %0d groups.",
             packer.samples_taken, reg_writes, packer.words_matched, packer.groups_made);
    $display("Sample requests were held back for %0d cycles by a full output side.",
             held_sample_cycles);
    if (packer.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
